@@ design/frg_pkg.sv @@
// Shared constants, codes and interface structs for the free rectangle grower.
`default_nettype none
package frg_pkg;

    // Grid and tile geometry
    localparam int GRID_DIM = 64;
    localparam int MAX_TILE = 16;
    localparam int ROW_W    = GRID_DIM;
    localparam int ADDR_W   = $clog2(GRID_DIM);
    localparam int CRD_W    = ADDR_W + 1;
    localparam int SUM_W    = CRD_W + 1;

    // Fixed field widths
    localparam int OP_W   = 2;
    localparam int XY_W   = 6;
    localparam int WH_W   = 5;
    localparam int CS_W   = 5;
    localparam int DIM_W  = 7;
    localparam int CIDX_W = 2;
    localparam int CDAT_W = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE     = 2'd0;
    localparam logic [OP_W-1:0] OP_GROW_TILE = 2'd1;
    localparam logic [OP_W-1:0] OP_GROW_FULL = 2'd2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_COVERAGE = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_WIDTH    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_HEIGHT   = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CS_W-1:0]  COVERAGE_RST = 5'd4;
    localparam logic [DIM_W-1:0] WIDTH_RST    = 7'd64;
    localparam logic [DIM_W-1:0] HEIGHT_RST   = 7'd64;

    // Row memory access
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [ROW_W-1:0]  wdata;
    } mem_req_t;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [CS_W-1:0]  cs;
        logic [DIM_W-1:0] lim_w;
        logic [DIM_W-1:0] lim_h;
    } cfg_eff_t;

    // One result
    typedef struct packed {
        logic            found;
        logic [XY_W-1:0] zone_x;
        logic [XY_W-1:0] zone_y;
        logic [WH_W-1:0] zone_w;
        logic [WH_W-1:0] zone_h;
    } result_t;

endpackage
`default_nettype wire

@@ design/frg_occ_mem.sv @@
// Occupancy bitmap: one row word per grid row, with per-row valid bits.
`default_nettype none
module frg_occ_mem (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire frg_pkg::mem_req_t           req,
    output logic [frg_pkg::ROW_W-1:0]        rdata
);

    logic [frg_pkg::ROW_W-1:0]    mem [frg_pkg::GRID_DIM];
    logic [frg_pkg::ROW_W-1:0]    mem_q;
    logic [frg_pkg::GRID_DIM-1:0] row_valid_reg;
    logic                         rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            mem_q <= mem[req.addr];
        end
    end

    // A row never written reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                row_valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[req.addr];
            end
        end
    end

    assign rdata = rd_valid_reg ? mem_q : '0;

endmodule
`default_nettype wire

@@ design/frg_grow_fsm.sv @@
// Request sequencer: row read-modify-write, tile origin and greedy growth.
`default_nettype none
module frg_grow_fsm (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [frg_pkg::OP_W-1:0]    op,
    input  wire logic [frg_pkg::XY_W-1:0]    seed_x,
    input  wire logic [frg_pkg::XY_W-1:0]    seed_y,
    input  wire logic                        occupied_bit,
    input  wire frg_pkg::cfg_eff_t           cfg,
    input  wire logic [frg_pkg::ROW_W-1:0]   mem_rdata,
    output frg_pkg::mem_req_t                mem_req,
    output logic                             busy,
    output logic                             done,
    output frg_pkg::result_t                 result
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_WRD  = 8'b0000_0010,
        S_SEED = 8'b0000_0100,
        S_TILE = 8'b0000_1000,
        S_GX   = 8'b0001_0000,
        S_YRD  = 8'b0010_0000,
        S_YCHK = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } state_t;

    state_t                           state_reg, state_next;
    logic                             done_reg, done_next;
    frg_pkg::result_t                 res_reg, res_next;
    logic [frg_pkg::OP_W-1:0]         op_reg, op_next;
    logic [frg_pkg::XY_W-1:0]         sx_reg, sx_next;
    logic [frg_pkg::XY_W-1:0]         sy_reg, sy_next;
    logic                             occ_reg, occ_next;
    logic [frg_pkg::CRD_W-1:0]        x0_reg, x0_next, x1_reg, x1_next;
    logic [frg_pkg::CRD_W-1:0]        y0_reg, y0_next, y1_reg, y1_next;
    logic [frg_pkg::CRD_W-1:0]        tx_reg, tx_next, ty_reg, ty_next;
    logic                             dir_reg, dir_next;
    logic [frg_pkg::ROW_W-1:0]        row_reg, row_next;
    logic [frg_pkg::ROW_W-1:0]        mask_reg, mask_next;

    logic [frg_pkg::CRD_W-1:0]        w, h, cs_c, sx_c, sy_c;
    logic [frg_pkg::SUM_W-1:0]        tx_end, ty_end;
    logic                             is_tile, in_grid, bound, cell_ok;
    logic [frg_pkg::CRD_W-1:0]        row_sel;
    logic [frg_pkg::ROW_W-1:0]        wdata;

    assign w       = x1_reg - x0_reg;
    assign h       = y1_reg - y0_reg;
    assign cs_c    = frg_pkg::CRD_W'(cfg.cs);
    assign sx_c    = frg_pkg::CRD_W'(sx_reg);
    assign sy_c    = frg_pkg::CRD_W'(sy_reg);
    assign tx_end  = frg_pkg::SUM_W'(tx_reg) + frg_pkg::SUM_W'(cfg.cs);
    assign ty_end  = frg_pkg::SUM_W'(ty_reg) + frg_pkg::SUM_W'(cfg.cs);
    assign is_tile = (op_reg == frg_pkg::OP_GROW_TILE);
    assign in_grid = (sx_c < cfg.lim_w) && (sy_c < cfg.lim_h);
    assign row_sel = dir_reg ? (y0_reg - 1'b1) : y1_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        op_next    = op_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        occ_next   = occ_reg;
        x0_next    = x0_reg;
        x1_next    = x1_reg;
        y0_next    = y0_reg;
        y1_next    = y1_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        dir_next   = dir_reg;
        row_next   = row_reg;
        mask_next  = mask_reg;
        mem_req    = '0;
        bound      = 1'b0;
        cell_ok    = 1'b0;
        wdata      = mem_rdata;
        wdata[sx_reg] = occ_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next        = op;
                    sx_next        = seed_x;
                    sy_next        = seed_y;
                    occ_next       = occupied_bit;
                    mem_req.rd_en  = 1'b1;
                    mem_req.addr   = seed_y;
                    if (op == frg_pkg::OP_WRITE)
                    begin
                        state_next = S_WRD;
                    end
                    else if (op == frg_pkg::OP_GROW_TILE || op == frg_pkg::OP_GROW_FULL)
                    begin
                        state_next = S_SEED;
                    end
                    else
                    begin
                        // unused op: empty result right away
                        res_next  = '0;
                        done_next = 1'b1;
                    end
                end
            end

            S_WRD:
            begin
                if (in_grid)
                begin
                    mem_req.wr_en = 1'b1;
                    mem_req.addr  = sy_reg;
                    mem_req.wdata = wdata;
                end
                res_next       = '0;
                res_next.found = in_grid;
                done_next      = 1'b1;
                state_next     = S_IDLE;
            end

            S_SEED:
            begin
                row_next = mem_rdata;
                if (in_grid && !mem_rdata[sx_reg])
                begin
                    x0_next    = sx_c;
                    x1_next    = sx_c + 1'b1;
                    y0_next    = sy_c;
                    y1_next    = sy_c + 1'b1;
                    tx_next    = '0;
                    ty_next    = '0;
                    state_next = S_TILE;
                end
                else
                begin
                    res_next   = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // tile origin by repeated add of the tile side
            S_TILE:
            begin
                if (tx_end <= frg_pkg::SUM_W'(sx_reg))
                begin
                    tx_next = tx_reg + cs_c;
                end
                if (ty_end <= frg_pkg::SUM_W'(sy_reg))
                begin
                    ty_next = ty_reg + cs_c;
                end
                if (!(tx_end <= frg_pkg::SUM_W'(sx_reg)) && !(ty_end <= frg_pkg::SUM_W'(sy_reg)))
                begin
                    dir_next   = 1'b0;
                    state_next = S_GX;
                end
            end

            // x growth only spans the seed row, already held in row_reg
            S_GX:
            begin
                if (!dir_reg)
                begin
                    bound   = is_tile ? ((frg_pkg::SUM_W'(x1_reg) + 1'b1) <= tx_end)
                                      : (w < cs_c);
                    cell_ok = (x1_reg < cfg.lim_w) && !row_reg[x1_reg[frg_pkg::ADDR_W-1:0]];
                end
                else
                begin
                    bound   = is_tile ? (x0_reg > tx_reg)
                                      : ((x0_reg != '0) && (w < cs_c));
                    cell_ok = !row_reg[frg_pkg::ADDR_W'(x0_reg - 1'b1)];
                end
                if (bound && cell_ok)
                begin
                    if (!dir_reg)
                    begin
                        x1_next = x1_reg + 1'b1;
                    end
                    else
                    begin
                        x0_next = x0_reg - 1'b1;
                    end
                end
                else if (!dir_reg)
                begin
                    dir_next = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < frg_pkg::ROW_W; i++)
                    begin
                        mask_next[i] = (frg_pkg::CRD_W'(i) >= x0_reg)
                                    && (frg_pkg::CRD_W'(i) < x1_reg);
                    end
                    dir_next   = 1'b0;
                    state_next = S_YRD;
                end
            end

            S_YRD:
            begin
                if (!dir_reg)
                begin
                    bound = is_tile ? ((frg_pkg::SUM_W'(y1_reg) + 1'b1) <= ty_end)
                                    : (h < cs_c);
                end
                else
                begin
                    bound = is_tile ? (y0_reg > ty_reg)
                                    : ((y0_reg != '0) && (h < cs_c));
                end
                if (bound && (row_sel < cfg.lim_h))
                begin
                    mem_req.rd_en = 1'b1;
                    mem_req.addr  = row_sel[frg_pkg::ADDR_W-1:0];
                    state_next    = S_YCHK;
                end
                else if (!dir_reg)
                begin
                    dir_next = 1'b1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_YCHK:
            begin
                if ((mem_rdata & mask_reg) == '0)
                begin
                    if (!dir_reg)
                    begin
                        y1_next = y1_reg + 1'b1;
                    end
                    else
                    begin
                        y0_next = y0_reg - 1'b1;
                    end
                    state_next = S_YRD;
                end
                else if (!dir_reg)
                begin
                    dir_next   = 1'b1;
                    state_next = S_YRD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                res_next = '0;
                if (is_tile || ((w == cs_c) && (h == cs_c)))
                begin
                    res_next.found  = 1'b1;
                    res_next.zone_x = x0_reg[frg_pkg::XY_W-1:0];
                    res_next.zone_y = y0_reg[frg_pkg::XY_W-1:0];
                    res_next.zone_w = w[frg_pkg::WH_W-1:0];
                    res_next.zone_h = h[frg_pkg::WH_W-1:0];
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            res_reg   <= '0;
            op_reg    <= frg_pkg::OP_WRITE;
            dir_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            res_reg   <= res_next;
            op_reg    <= op_next;
            dir_reg   <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        occ_reg  <= occ_next;
        x0_reg   <= x0_next;
        x1_reg   <= x1_next;
        y0_reg   <= y0_next;
        y1_reg   <= y1_next;
        tx_reg   <= tx_next;
        ty_reg   <= ty_next;
        row_reg  <= row_next;
        mask_reg <= mask_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

@@ design/free_rectangle_grower.sv @@
// Top level: configuration registers, occupancy memory and growth sequencer.
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  -------------------------------------------
//  request   start & !busy             op, seed_x, seed_y, occupied_bit
//  result    done (one-cycle strobe)   found, zone_x, zone_y, zone_w, zone_h
//  config    cfg_valid & cfg_ready     cfg_index, cfg_data
//
//  Steps: a write reads the row, then writes it back when in the grid. Unused op
//  answers the cycle after the request. A grow reads the seed row (an occupied or
//  off-grid seed ends it with a miss), steps the tile origin, grows x on the held
//  seed row, grows y with one row read per y step, then registers the result. The
//  row memory is single-port, so each y step is one row read.
//  Reset: async, active low; the bitmap reads all free through per-row valid
//  bits, so no clearing pass is needed. The receiver cannot stall results.
`default_nettype none
module free_rectangle_grower (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [frg_pkg::OP_W-1:0]      op,
    input  wire logic [frg_pkg::XY_W-1:0]      seed_x,
    input  wire logic [frg_pkg::XY_W-1:0]      seed_y,
    input  wire logic                          occupied_bit,
    // result channel
    output logic                               done,
    output logic                               found,
    output logic [frg_pkg::XY_W-1:0]           zone_x,
    output logic [frg_pkg::XY_W-1:0]           zone_y,
    output logic [frg_pkg::WH_W-1:0]           zone_w,
    output logic [frg_pkg::WH_W-1:0]           zone_h,
    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [frg_pkg::CIDX_W-1:0]    cfg_index,
    input  wire logic [frg_pkg::CDAT_W-1:0]    cfg_data
);

    logic [frg_pkg::CS_W-1:0]  coverage_reg;
    logic [frg_pkg::DIM_W-1:0] width_reg;
    logic [frg_pkg::DIM_W-1:0] height_reg;

    frg_pkg::cfg_eff_t  cfg;
    frg_pkg::mem_req_t  mem_req;
    frg_pkg::result_t   result;
    logic [frg_pkg::ROW_W-1:0] mem_rdata;

    // Config writes are always taken; the host must write only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coverage_reg <= frg_pkg::COVERAGE_RST;
            width_reg    <= frg_pkg::WIDTH_RST;
            height_reg   <= frg_pkg::HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                frg_pkg::CFG_COVERAGE: coverage_reg <= cfg_data[frg_pkg::CS_W-1:0];
                frg_pkg::CFG_WIDTH:    width_reg    <= cfg_data;
                frg_pkg::CFG_HEIGHT:   height_reg   <= cfg_data;
                default:               ;  // unknown index: ignored
            endcase
        end
    end

    // Clamp: tile side 0 acts as 1, above MAX_TILE as MAX_TILE; grid dims cap at GRID_DIM.
    always_comb
    begin
        if (coverage_reg == '0)
        begin
            cfg.cs = frg_pkg::CS_W'(1);
        end
        else if (coverage_reg > frg_pkg::CS_W'(frg_pkg::MAX_TILE))
        begin
            cfg.cs = frg_pkg::CS_W'(frg_pkg::MAX_TILE);
        end
        else
        begin
            cfg.cs = coverage_reg;
        end
        cfg.lim_w = (width_reg > frg_pkg::DIM_W'(frg_pkg::GRID_DIM))
                  ? frg_pkg::DIM_W'(frg_pkg::GRID_DIM) : width_reg;
        cfg.lim_h = (height_reg > frg_pkg::DIM_W'(frg_pkg::GRID_DIM))
                  ? frg_pkg::DIM_W'(frg_pkg::GRID_DIM) : height_reg;
    end

    frg_occ_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    frg_grow_fsm u_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op),
        .seed_x       (seed_x),
        .seed_y       (seed_y),
        .occupied_bit (occupied_bit),
        .cfg          (cfg),
        .mem_rdata    (mem_rdata),
        .mem_req      (mem_req),
        .busy         (busy),
        .done         (done),
        .result       (result)
    );

    assign found  = result.found;
    assign zone_x = result.zone_x;
    assign zone_y = result.zone_y;
    assign zone_w = result.zone_w;
    assign zone_h = result.zone_h;

    // A result strobe always coincides with the sequencer back at idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    // Leaving a busy phase always delivers a result.
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("request finished without a result");

    // A miss carries an all-zero zone.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (zone_x == '0 && zone_y == '0 && zone_w == '0 && zone_h == '0))
        else $error("zone fields nonzero on a miss");

    // A zone never exceeds the largest tile.
    a_zone_size: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (zone_w <= frg_pkg::WH_W'(frg_pkg::MAX_TILE)
               && zone_h <= frg_pkg::WH_W'(frg_pkg::MAX_TILE)))
        else $error("zone larger than tile");

endmodule
`default_nettype wire

@@ tb/sv/free_rectangle_grower_checker.sv @@
// Checker: mirrors the occupancy bitmap, predicts every zone and compares the results.
module free_rectangle_grower_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [frg_pkg::OP_W-1:0]     op,
    input  logic [frg_pkg::XY_W-1:0]     seed_x,
    input  logic [frg_pkg::XY_W-1:0]     seed_y,
    input  logic                         occupied_bit,
    input  logic                         done,
    input  logic                         found,
    input  logic [frg_pkg::XY_W-1:0]     zone_x,
    input  logic [frg_pkg::XY_W-1:0]     zone_y,
    input  logic [frg_pkg::WH_W-1:0]     zone_w,
    input  logic [frg_pkg::WH_W-1:0]     zone_h,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [frg_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [frg_pkg::CDAT_W-1:0]   cfg_data,
    output int                           fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import frg_pkg::*;

    logic             occ_map [GRID_DIM*GRID_DIM];
    logic [CS_W-1:0]  cov_reg;
    logic [DIM_W-1:0] wid_reg;
    logic [DIM_W-1:0] hgt_reg;
    result_t          zones_due [$];
    int               mismatches;

    function automatic int cols_in_use();
        return (wid_reg > GRID_DIM) ? GRID_DIM : int'(wid_reg);
    endfunction

    function automatic int rows_in_use();
        return (hgt_reg > GRID_DIM) ? GRID_DIM : int'(hgt_reg);
    endfunction

    function automatic int tile_edge();
        if (cov_reg == 0) return 1;
        if (cov_reg > MAX_TILE) return MAX_TILE;
        return int'(cov_reg);
    endfunction

    // off-grid cells read as occupied
    function automatic bit cell_open(int x, int y);
        if (x < 0 || y < 0 || x >= cols_in_use() || y >= rows_in_use()) return 1'b0;
        return !occ_map[y*GRID_DIM + x];
    endfunction

    function automatic bit column_open(int x, int ylo, int yhi);
        for (int y = ylo; y < yhi; y++)
            if (!cell_open(x, y)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit row_open(int y, int xlo, int xhi);
        for (int x = xlo; x < xhi; x++)
            if (!cell_open(x, y)) return 1'b0;
        return 1'b1;
    endfunction

    // applies one request to the mirrored bitmap and returns the zone it should yield
    function automatic result_t grow_zone(logic [OP_W-1:0] code, int sx, int sy, logic occ);
        result_t r;
        int      cs;
        int      x0;
        int      x1;
        int      y0;
        int      y1;
        int      tx;
        int      ty;
        bit      ok;
        r  = '0;
        cs = tile_edge();
        if (code == OP_WRITE)
        begin
            if (sx < cols_in_use() && sy < rows_in_use())
            begin
                occ_map[sy*GRID_DIM + sx] = occ;
                r.found = 1'b1;
            end
            return r;
        end
        if (code != OP_GROW_TILE && code != OP_GROW_FULL) return r;
        if (!cell_open(sx, sy)) return r;
        x0 = sx;
        x1 = sx + 1;
        y0 = sy;
        y1 = sy + 1;
        if (code == OP_GROW_TILE)
        begin
            tx = (sx / cs) * cs;
            ty = (sy / cs) * cs;
            while (x1 + 1 <= tx + cs && column_open(x1, y0, y1)) x1++;
            while (x0 - 1 >= tx && column_open(x0 - 1, y0, y1)) x0--;
            while (y1 + 1 <= ty + cs && row_open(y1, x0, x1)) y1++;
            while (y0 - 1 >= ty && row_open(y0 - 1, x0, x1)) y0--;
            ok = 1'b1;
        end
        else
        begin
            while (x1 + 1 - x0 <= cs && column_open(x1, y0, y1)) x1++;
            while (x1 - (x0 - 1) <= cs && column_open(x0 - 1, y0, y1)) x0--;
            while (y1 + 1 - y0 <= cs && row_open(y1, x0, x1)) y1++;
            while (y1 - (y0 - 1) <= cs && row_open(y0 - 1, x0, x1)) y0--;
            ok = (x1 - x0 == cs) && (y1 - y0 == cs);
        end
        if (ok)
        begin
            r.found  = 1'b1;
            r.zone_x = XY_W'(x0);
            r.zone_y = XY_W'(y0);
            r.zone_w = WH_W'(x1 - x0);
            r.zone_h = WH_W'(y1 - y0);
        end
        return r;
    endfunction

    task automatic check_field(string name, int want_v, int got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t due;
        if (!rst_n)
        begin
            for (int i = 0; i < GRID_DIM*GRID_DIM; i++) occ_map[i] = 1'b0;
            cov_reg    = COVERAGE_RST;
            wid_reg    = WIDTH_RST;
            hgt_reg    = HEIGHT_RST;
            mismatches = 0;
            zones_due.delete();
        end
        else
        begin
            // result first, so a request taken at the same edge never matches it
            if (done)
            begin
                if (zones_due.size() == 0)
                begin
                    $display("%0t: extra result, expected none, got %0b %0d %0d %0d %0d",
                             $time, found, zone_x, zone_y, zone_w, zone_h);
                    mismatches++;
                end
                else
                begin
                    want = zones_due.pop_front();
                    check_field("found",  int'(want.found),  int'(found));
                    check_field("zone_x", int'(want.zone_x), int'(zone_x));
                    check_field("zone_y", int'(want.zone_y), int'(zone_y));
                    check_field("zone_w", int'(want.zone_w), int'(zone_w));
                    check_field("zone_h", int'(want.zone_h), int'(zone_h));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_COVERAGE: cov_reg = cfg_data[CS_W-1:0];
                    CFG_WIDTH:    wid_reg = cfg_data;
                    CFG_HEIGHT:   hgt_reg = cfg_data;
                    default:      ;
                endcase
            end
            if (start && !busy)
            begin
                due = grow_zone(op, int'(seed_x), int'(seed_y), occupied_bit);
                zones_due.insert(zones_due.size(), due);
            end
        end
        // anything still waiting counts against the run
        fail_count = mismatches + zones_due.size();
    end

endmodule

@@ tb/sv/free_rectangle_grower_tb.sv @@
// Testbench top: clock, reset, request and register stimulus, and the final verdict.
module free_rectangle_grower_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frg_pkg::*;

    // op code and register index the package leaves unnamed; both must be harmless
    localparam logic [OP_W-1:0]   OP_UNUSED  = 2'd3;
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1300;
    // watchdog limit on cycle_count for the whole run
    localparam int CYCLE_LIMIT  = 4_000_000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     op;
    logic [XY_W-1:0]     seed_x;
    logic [XY_W-1:0]     seed_y;
    logic                occupied_bit;
    logic                done;
    logic                found;
    logic [XY_W-1:0]     zone_x;
    logic [XY_W-1:0]     zone_y;
    logic [WH_W-1:0]     zone_w;
    logic [WH_W-1:0]     zone_h;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index;
    logic [CDAT_W-1:0]   cfg_data;
    int                  fail_count;

    // bookkeeping for pacing: requests taken vs results strobed
    int                  requests_taken;
    int                  zones_seen = 0;
    int                  counted;
    int                  cycle_count = 0;
    bit                  pace_on;
    // effective settings, tracked so stimulus stays mostly inside the grid
    int                  cur_cs;
    int                  cur_w;
    int                  cur_h;

    free_rectangle_grower uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .seed_x       (seed_x),
        .seed_y       (seed_y),
        .occupied_bit (occupied_bit),
        .done         (done),
        .found        (found),
        .zone_x       (zone_x),
        .zone_y       (zone_y),
        .zone_w       (zone_w),
        .zone_h       (zone_h),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    free_rectangle_grower_checker zone_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .seed_x       (seed_x),
        .seed_y       (seed_y),
        .occupied_bit (occupied_bit),
        .done         (done),
        .found        (found),
        .zone_x       (zone_x),
        .zone_y       (zone_y),
        .zone_w       (zone_w),
        .zone_h       (zone_h),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // results cannot be held off; just count the strobes (nonblocking, so
    // readers at the same edge always see the previous count)
    always @(posedge clk)
    begin
        if (rst_n && done) zones_seen <= zones_seen + 1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** free_rectangle_grower: FAILED **");
            $finish;
        end
    end

    // One request. The sender may idle first when pacing is on; start
    // stays high across back-to-back requests so it never toggles within a step.
    task automatic issue(logic [OP_W-1:0] code, int x, int y, logic occ_bit);
        int gap;
        gap = pace_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        op           <= code;
        seed_x       <= XY_W'(x);
        seed_y       <= XY_W'(y);
        occupied_bit <= occ_bit;
        @(posedge clk);
        while (busy) @(posedge clk);
        requests_taken++;
        // writes outside the grid and the unused op are ignored by the block
        if (code == OP_GROW_TILE || code == OP_GROW_FULL ||
            (code == OP_WRITE && (x & 63) < cur_w && (y & 63) < cur_h))
            counted++;
    endtask

    // drop start and wait until every request has produced its result
    task automatic settle();
        start <= 1'b0;
        while (zones_seen != requests_taken) @(posedge clk);
    endtask

    task automatic put_reg(logic [CIDX_W-1:0] idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CDAT_W'(val);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Rewrite all three registers while idle. Never called twice in a row, so
    // cfg_valid is not lowered and raised in the same step.
    task automatic write_regs(int cs_val, int w_val, int h_val, bit junk);
        settle();
        if (junk) put_reg(CFG_UNUSED, $urandom_range(0, 127));
        put_reg(CFG_COVERAGE, cs_val);
        put_reg(CFG_WIDTH, w_val);
        put_reg(CFG_HEIGHT, h_val);
        cfg_valid <= 1'b0;
        cs_val = cs_val & 31;
        cur_cs = (cs_val == 0) ? 1 : (cs_val > MAX_TILE) ? MAX_TILE : cs_val;
        cur_w  = ((w_val & 127) > GRID_DIM) ? GRID_DIM : (w_val & 127);
        cur_h  = ((h_val & 127) > GRID_DIM) ? GRID_DIM : (h_val & 127);
    endtask

    // mostly inside the grid in use, now and then anywhere
    function automatic int pick_coord(int span);
        if (span == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 63);
        return $urandom_range(0, span - 1);
    endfunction

    // Well-formed pocket: clear a few cells around a focus, drop up to two obstacles
    // within a tile's reach, then grow from the focus both ways.
    task automatic pocket();
        int fx;
        int fy;
        fx = pick_coord(cur_w);
        fy = pick_coord(cur_h);
        repeat ($urandom_range(2, 8))
            issue(OP_WRITE, (fx + $urandom_range(0, 4) - 2) & 63,
                  (fy + $urandom_range(0, 4) - 2) & 63, 1'b0);
        issue(OP_WRITE, fx, fy, 1'b0);
        repeat ($urandom_range(0, 2))
            issue(OP_WRITE, (fx + $urandom_range(0, 2*cur_cs) - cur_cs) & 63,
                  (fy + $urandom_range(0, 2*cur_cs) - cur_cs) & 63, 1'b1);
        issue(OP_GROW_TILE, fx, fy, 1'($urandom_range(0, 1)));
        issue(OP_GROW_FULL, fx, fy, 1'($urandom_range(0, 1)));
    endtask

    // Clear one whole tile, then grow from a cell in it; the only practical way
    // to see full-tile zones with large tiles on a busy bitmap.
    task automatic sweep();
        int ox;
        int oy;
        ox = (pick_coord(cur_w) / cur_cs) * cur_cs;
        oy = (pick_coord(cur_h) / cur_cs) * cur_cs;
        for (int dy = 0; dy < cur_cs; dy++)
            for (int dx = 0; dx < cur_cs; dx++)
                issue(OP_WRITE, (ox + dx) & 63, (oy + dy) & 63, 1'b0);
        issue(OP_GROW_FULL, (ox + $urandom_range(0, cur_cs - 1)) & 63,
              (oy + $urandom_range(0, cur_cs - 1)) & 63, 1'b0);
        issue(OP_GROW_TILE, (ox + $urandom_range(0, cur_cs - 1)) & 63,
              (oy + $urandom_range(0, cur_cs - 1)) & 63, 1'b1);
    endtask

    function automatic int draw_tile();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return $urandom_range(1, 6);
        if (r < 16) return $urandom_range(7, 16);
        if (r == 16) return 0;
        if (r == 17) return $urandom_range(17, 31);
        return $urandom_range(0, 127);     // upper bits masked off by the block
    endfunction

    function automatic int draw_span();
        int r;
        r = $urandom_range(0, 19);
        if (r < 7) return GRID_DIM;
        if (r < 15) return $urandom_range(8, 63);
        if (r < 17) return $urandom_range(1, 7);
        if (r == 17) return 0;
        return $urandom_range(65, 127);
    endfunction

    initial
    begin
        int density;
        int r;
        logic [OP_W-1:0] code;

        rst_n          = 1'b0;
        start          = 1'b0;
        op             = OP_WRITE;
        seed_x         = '0;
        seed_y         = '0;
        occupied_bit   = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_COVERAGE;
        cfg_data       = '0;
        requests_taken = 0;
        counted        = 0;
        pace_on        = 1'b1;
        cur_cs         = int'(COVERAGE_RST);
        cur_w          = int'(WIDTH_RST);
        cur_h          = int'(HEIGHT_RST);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: reset settings, tile side 4 on a 64x64 grid ----
        issue(OP_GROW_TILE, 0, 0, 1'b0);      // empty map, first tile
        issue(OP_GROW_FULL, 63, 63, 1'b1);    // grows back toward the origin
        issue(OP_WRITE, 63, 63, 1'b1);
        issue(OP_GROW_TILE, 63, 63, 1'b0);    // occupied seed
        issue(OP_GROW_FULL, 63, 63, 1'b0);    // occupied seed, full-tile mode
        issue(OP_WRITE, 63, 63, 1'b0);
        issue(OP_UNUSED, 21, 42, 1'b1);       // unused op answers all zeros
        issue(OP_WRITE, 6, 5, 1'b1);          // obstacle next to the seed
        issue(OP_GROW_TILE, 5, 5, 1'b0);
        issue(OP_GROW_FULL, 5, 5, 1'b0);

        // largest tile, plus a write to the unused register index
        write_regs(16, 64, 64, 1'b1);
        issue(OP_GROW_FULL, 32, 32, 1'b0);
        issue(OP_GROW_TILE, 40, 50, 1'b1);

        // tile size 0 acts as 1, width above the grid clamps, single row
        write_regs(0, 127, 1, 1'b0);
        issue(OP_GROW_TILE, 10, 0, 1'b0);
        issue(OP_GROW_FULL, 63, 0, 1'b0);
        issue(OP_WRITE, 5, 1, 1'b1);          // below the last row: ignored
        issue(OP_GROW_TILE, 5, 1, 1'b0);      // seed off the grid

        // oversized tile clamps to the maximum, empty grid
        write_regs(31, 0, 0, 1'b0);
        issue(OP_WRITE, 0, 0, 1'b1);
        issue(OP_GROW_FULL, 0, 0, 1'b0);

        // single column
        write_regs(1, 1, 64, 1'b0);
        issue(OP_GROW_TILE, 0, 63, 1'b0);
        issue(OP_GROW_FULL, 1, 0, 1'b0);      // right of the only column
        issue(OP_WRITE, 0, 10, 1'b1);
        issue(OP_GROW_TILE, 0, 10, 1'b0);

        // ---- random phases: new settings, then a mix of pockets and noise ----
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            write_regs(draw_tile(), draw_span(), draw_span(), $urandom_range(0, 7) == 0);
            pace_on = $urandom_range(0, 3) != 0;   // some phases run flat out
            density = $urandom_range(5, 50);
            repeat (60)
            begin
                r = $urandom_range(0, 299);
                if (r < 2)
                begin
                    sweep();
                end
                else if (r < 60)
                begin
                    pocket();
                end
                else if (r < 80)
                begin
                    // noise: any op, any coordinate
                    issue(OP_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                          $urandom_range(0, 63), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    code = (r < 45) ? OP_WRITE : (r < 72) ? OP_GROW_TILE : OP_GROW_FULL;
                    issue(code, pick_coord(cur_w), pick_coord(cur_h),
                          $urandom_range(0, 99) < density);
                end
            end
        end

        // drain, then allow for a last grow in flight
        settle();
        repeat (300) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("** free_rectangle_grower: PASSED **");
        else
            $display("** free_rectangle_grower: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
design/frg_pkg.sv
design/frg_occ_mem.sv
design/frg_grow_fsm.sv
design/free_rectangle_grower.sv
tb/sv/free_rectangle_grower_checker.sv
tb/sv/free_rectangle_grower_tb.sv
